[rtl/indexed_framebuffer_blit_palette_macros.svh]
// assertion macros for the palette framebuffer block
`ifndef INDEXED_FRAMEBUFFER_BLIT_PALETTE_MACROS_SVH
`define INDEXED_FRAMEBUFFER_BLIT_PALETTE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define IFBP_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define IFBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IFBP_ASSERT(lbl, ante, cons, msg)
`define IFBP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/ifbp_pkg.sv]
// shared types, codes and helpers of the palette framebuffer block
package ifbp_pkg;

  localparam int DIM_W  = 9;
  localparam int CRD_W  = 8;
  localparam int CLR_W  = 8;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;

  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BLIT   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_UNSET = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

  localparam logic [0:0] CFG_FB_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_FB_HEIGHT = 1'b1;

  typedef logic [DIM_W-1:0] dim_t;
  typedef logic [CRD_W-1:0] crd_t;

  typedef struct packed {
    dim_t dvd_x;
    dim_t dvd_y;
    dim_t div_x;
    dim_t div_y;
  } mod_req_t;

  typedef struct packed {
    dim_t rem_x;
    dim_t rem_y;
    logic done;
  } mod_rsp_t;

  function automatic dim_t clamp_dim(dim_t v, dim_t maxv);
    if (v == '0) begin
      return dim_t'(1);
    end
    if (v > maxv) begin
      return maxv;
    end
    return v;
  endfunction

endpackage

[rtl/ifbp_ram.sv]
// generic single-port ram with registered read
module ifbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/ifbp_mod.sv]
// two-lane bit-serial remainder unit for the blit position wrap
module ifbp_mod import ifbp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIM_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  dim_t             dvd_x_r;
  dim_t             dvd_y_r;
  dim_t             div_x_r;
  dim_t             div_y_r;
  dim_t             rem_x_r;
  dim_t             rem_y_r;
  dim_t             trial_x;
  dim_t             trial_y;
  dim_t             rem_x_nxt;
  dim_t             rem_y_nxt;

  always_comb begin
    trial_x   = {rem_x_r[DIM_W-2:0], dvd_x_r[DIM_W-1]};
    trial_y   = {rem_y_r[DIM_W-2:0], dvd_y_r[DIM_W-1]};
    rem_x_nxt = (trial_x >= div_x_r) ? trial_x - div_x_r : trial_x;
    rem_y_nxt = (trial_y >= div_y_r) ? trial_y - div_y_r : trial_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_x_r <= req.dvd_x;
      dvd_y_r <= req.dvd_y;
      div_x_r <= req.div_x;
      div_y_r <= req.div_y;
      rem_x_r <= '0;
      rem_y_r <= '0;
    end else if (busy_r) begin
      dvd_x_r <= {dvd_x_r[DIM_W-2:0], 1'b0};
      dvd_y_r <= {dvd_y_r[DIM_W-2:0], 1'b0};
      rem_x_r <= rem_x_nxt;
      rem_y_r <= rem_y_nxt;
    end
  end

  assign rsp.rem_x = rem_x_r;
  assign rsp.rem_y = rem_y_r;
  assign rsp.done  = done_r;

endmodule

[rtl/indexed_framebuffer_blit_palette.sv]
// top level of the palette-indexed framebuffer with wrapping sprite blit
// The block handles one transaction at a time. After reset it runs a clearing pass that writes
// zero to all MAX_WIDTH*MAX_HEIGHT frame entries (65536 at the defaults), takes no transaction
// until it ends and takes configuration writes throughout. A palette append passes the append
// state; a read the address, frame read, palette check and palette read states (none when the
// coordinate is outside the frame); a blit pixel the wrap, address and write states, its
// position wrapped by the bit-serial remainder unit, one bit per cycle over 9 bits. The next
// transaction is accepted once the result is in the output register, which holds it until taken.
module indexed_framebuffer_blit_palette import ifbp_pkg::*; #(
  parameter int MAX_WIDTH     = 256,
  parameter int MAX_HEIGHT    = 256,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [DIM_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [CRD_W-1:0]  in_offset_x,
  input  logic [CRD_W-1:0]  in_offset_y,
  input  logic [CRD_W-1:0]  in_sprite_width,
  input  logic [CRD_W-1:0]  in_sprite_height,
  input  logic [CRD_W-1:0]  in_pixel_index,
  input  logic [CLR_W-1:0]  in_red,
  input  logic [CLR_W-1:0]  in_green,
  input  logic [CLR_W-1:0]  in_blue,
  input  logic [CRD_W-1:0]  in_read_x,
  input  logic [CRD_W-1:0]  in_read_y,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CLR_W-1:0]  out_red,
  output logic [CLR_W-1:0]  out_green,
  output logic [CLR_W-1:0]  out_blue,
  output logic [STAT_W-1:0] out_status,
  output logic              out_sprite_done
);

`include "indexed_framebuffer_blit_palette_macros.svh"

  localparam int FDEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int FAW    = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
  localparam int PAW    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int PCW    = $clog2(PALETTE_DEPTH + 1);
  localparam int CMP_W  = (PCW > CRD_W) ? PCW : CRD_W;
  localparam int PROD_W = DIM_W + CRD_W;
  localparam int RGB_W  = 3 * CLR_W;

  localparam logic [3:0] ST_CLR    = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_DIV    = 4'd2;
  localparam logic [3:0] ST_ADDR   = 4'd3;
  localparam logic [3:0] ST_WRITE  = 4'd4;
  localparam logic [3:0] ST_FRD    = 4'd5;
  localparam logic [3:0] ST_PCHK   = 4'd6;
  localparam logic [3:0] ST_PRD    = 4'd7;
  localparam logic [3:0] ST_APPEND = 4'd8;
  localparam logic [3:0] ST_FIN    = 4'd9;

  logic [3:0]        state_r;
  logic [3:0]        state_nxt;
  dim_t              fb_width_r;
  dim_t              fb_height_r;
  dim_t              w_eff;
  dim_t              h_eff;
  logic [FAW-1:0]    clr_addr_r;
  logic [PCW-1:0]    pal_count_r;
  crd_t              col_r;
  crd_t              row_r;
  logic [REQ_W-1:0]  req_r;
  crd_t              pix_r;
  logic [RGB_W-1:0]  rgb_r;
  crd_t              pos_x_r;
  crd_t              pos_y_r;
  logic [FAW-1:0]    addr_r;
  logic [PROD_W-1:0] addr_full;
  logic [CLR_W-1:0]  res_red_r;
  logic [CLR_W-1:0]  res_green_r;
  logic [CLR_W-1:0]  res_blue_r;
  logic [STAT_W-1:0] res_status_r;
  logic              res_done_r;
  logic              out_valid_r;
  logic [CLR_W-1:0]  out_red_r;
  logic [CLR_W-1:0]  out_green_r;
  logic [CLR_W-1:0]  out_blue_r;
  logic [STAT_W-1:0] out_status_r;
  logic              out_done_r;
  logic              accept;
  logic              load_out;
  logic              read_outside;
  logic              idx_unset;
  logic              pal_full;
  crd_t              sw_eff;
  crd_t              sh_eff;
  logic              col_last;
  logic              row_last;
  mod_req_t          mod_req;
  mod_rsp_t          mod_rsp;
  logic              frame_we;
  logic [FAW-1:0]    frame_addr;
  crd_t              frame_wdata;
  crd_t              frame_rdata;
  logic              pal_we;
  logic [PAW-1:0]    pal_addr;
  logic [RGB_W-1:0]  pal_rdata;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign load_out  = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  assign w_eff = clamp_dim(fb_width_r, DIM_W'(MAX_WIDTH));
  assign h_eff = clamp_dim(fb_height_r, DIM_W'(MAX_HEIGHT));

  assign read_outside = ({1'b0, in_read_x} >= w_eff) || ({1'b0, in_read_y} >= h_eff);
  assign idx_unset    = CMP_W'(frame_rdata) >= CMP_W'(pal_count_r);
  assign pal_full     = pal_count_r >= PCW'(PALETTE_DEPTH);

  assign sw_eff   = (in_sprite_width == '0) ? crd_t'(1) : in_sprite_width;
  assign sh_eff   = (in_sprite_height == '0) ? crd_t'(1) : in_sprite_height;
  assign col_last = ({1'b0, col_r} + (CRD_W + 1)'(1)) >= {1'b0, sw_eff};
  assign row_last = ({1'b0, row_r} + (CRD_W + 1)'(1)) >= {1'b0, sh_eff};

  assign addr_full = PROD_W'(w_eff) * PROD_W'(pos_y_r) + PROD_W'(pos_x_r);

  assign mod_req.dvd_x = DIM_W'(in_offset_x) + DIM_W'(col_r);
  assign mod_req.dvd_y = DIM_W'(in_offset_y) + DIM_W'(row_r);
  assign mod_req.div_x = w_eff;
  assign mod_req.div_y = h_eff;

  ifbp_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept && (in_req_type == REQ_BLIT)),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  assign frame_we    = (state_r == ST_CLR) || (state_r == ST_WRITE);
  assign frame_addr  = (state_r == ST_CLR) ? clr_addr_r : addr_r;
  assign frame_wdata = (state_r == ST_CLR) ? '0 : pix_r;

  ifbp_ram #(
    .WIDTH (CRD_W),
    .DEPTH (FDEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (frame_we),
    .addr  (frame_addr),
    .wdata (frame_wdata),
    .rdata (frame_rdata)
  );

  assign pal_we   = (state_r == ST_APPEND) && !pal_full;
  assign pal_addr = (state_r == ST_APPEND) ? pal_count_r[PAW-1:0] : frame_rdata[PAW-1:0];

  ifbp_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .addr  (pal_addr),
    .wdata (rgb_r),
    .rdata (pal_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR: begin
        if (clr_addr_r == FAW'(FDEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_req_type)
            REQ_APPEND: state_nxt = ST_APPEND;
            REQ_BLIT:   state_nxt = ST_DIV;
            REQ_READ:   state_nxt = read_outside ? ST_FIN : ST_ADDR;
            default:    state_nxt = ST_FIN;
          endcase
        end
      end
      ST_DIV: begin
        if (mod_rsp.done) begin
          state_nxt = ST_ADDR;
        end
      end
      ST_ADDR:   state_nxt = (req_r == REQ_BLIT) ? ST_WRITE : ST_FRD;
      ST_WRITE:  state_nxt = ST_FIN;
      ST_FRD:    state_nxt = ST_PCHK;
      ST_PCHK:   state_nxt = idx_unset ? ST_FIN : ST_PRD;
      ST_PRD:    state_nxt = ST_FIN;
      ST_APPEND: state_nxt = ST_FIN;
      ST_FIN: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_addr_r  <= '0;
      fb_width_r  <= DIM_W'(256);
      fb_height_r <= DIM_W'(256);
      pal_count_r <= '0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) begin
        clr_addr_r <= clr_addr_r + FAW'(1);
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_FB_WIDTH:  fb_width_r  <= cfg_data;
          CFG_FB_HEIGHT: fb_height_r <= cfg_data;
          default:       fb_width_r  <= fb_width_r;
        endcase
      end
      if (pal_we) begin
        pal_count_r <= pal_count_r + PCW'(1);
      end
      if (accept && (in_req_type == REQ_BLIT)) begin
        if (col_last) begin
          col_r <= '0;
          row_r <= row_last ? '0 : row_r + crd_t'(1);
        end else begin
          col_r <= col_r + crd_t'(1);
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // transaction payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r        <= in_req_type;
      pix_r        <= in_pixel_index;
      rgb_r        <= {in_red, in_green, in_blue};
      pos_x_r      <= in_read_x;
      pos_y_r      <= in_read_y;
      res_red_r    <= '0;
      res_green_r  <= '0;
      res_blue_r   <= '0;
      res_status_r <= ((in_req_type == REQ_READ) && read_outside) ? STAT_RANGE : STAT_OK;
      res_done_r   <= (in_req_type == REQ_BLIT) && col_last && row_last;
    end
    if ((state_r == ST_DIV) && mod_rsp.done) begin
      pos_x_r <= mod_rsp.rem_x[CRD_W-1:0];
      pos_y_r <= mod_rsp.rem_y[CRD_W-1:0];
    end
    if (state_r == ST_ADDR) begin
      addr_r <= addr_full[FAW-1:0];
    end
    if ((state_r == ST_PCHK) && idx_unset) begin
      res_status_r <= STAT_UNSET;
    end
    if (state_r == ST_PRD) begin
      res_red_r   <= pal_rdata[RGB_W-1 -: CLR_W];
      res_green_r <= pal_rdata[CLR_W +: CLR_W];
      res_blue_r  <= pal_rdata[CLR_W-1:0];
    end
    if ((state_r == ST_APPEND) && pal_full) begin
      res_status_r <= STAT_FULL;
    end
    if (load_out) begin
      out_red_r    <= res_red_r;
      out_green_r  <= res_green_r;
      out_blue_r   <= res_blue_r;
      out_status_r <= res_status_r;
      out_done_r   <= res_done_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red         = out_red_r;
  assign out_green       = out_green_r;
  assign out_blue        = out_blue_r;
  assign out_status      = out_status_r;
  assign out_sprite_done = out_done_r;

  `IFBP_ASSERT(a_clr_no_accept, state_r == ST_CLR, in_stall, "transaction during clearing pass")
  `IFBP_ASSERT(a_pal_count, 1'b1, pal_count_r <= PCW'(PALETTE_DEPTH), "palette count overflow")
  `IFBP_ASSERT(a_done_blit, load_out && res_done_r, (req_r == REQ_BLIT) && (res_status_r == STAT_OK), "sprite done on non-blit")
  `IFBP_ASSERT(a_mod_in_div, mod_rsp.done, state_r == ST_DIV, "remainder done outside wrap state")
  `IFBP_ASSERT_NEXT(a_fin_hold, (state_r == ST_FIN) && out_valid_r && out_stall, state_r == ST_FIN, "result lost while output stalled")

endmodule
